// ===== src/arpre_pkg.sv =====
// Shared types, constants and stream field offsets of the ARP resolution engine.
// No dependencies; every other file in src but arpre_ram imports it.
`default_nettype none
package arpre_pkg;

    localparam int CACHE_ENTRIES_DEF   = 16;
    localparam int PENDING_ENTRIES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 8;
    localparam int MAX_RESULTS         = 10;
    localparam int FLUSH_MAX           = MAX_RESULTS - 1;

    localparam int IN_W  = 264;
    localparam int OUT_W = 96;
    localparam int CFG_W = 48;

    localparam logic [31:0] LIFETIME_RST = 32'd30000;
    localparam logic [31:0] HOLDOFF_RST  = 32'd5000;
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ETH_ARP      = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ   = 16'd1;
    localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [1:0] REG_OWN_IP   = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;
    localparam logic [1:0] REG_HOLDOFF  = 2'd3;

    // input tdata offsets, lowest bit of each field
    localparam int IN_NH   = 0;
    localparam int IN_HND  = 32;
    localparam int IN_DST  = 48;
    localparam int IN_ET   = 96;
    localparam int IN_OK   = 112;
    localparam int IN_OPC  = 113;
    localparam int IN_SIP  = 129;
    localparam int IN_SMAC = 161;
    localparam int IN_TIP  = 209;
    localparam int IN_EL   = 241;

    typedef enum logic [1:0] {
        KIND_IPV4    = 2'd0,
        KIND_ARP_REQ = 2'd1,
        KIND_ARP_REP = 2'd2,
        KIND_DELIVER = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EM_HIT,
        EM_BCAST,
        EM_DELIVER,
        EM_FLUSH,
        EM_REPLY
    } t_emit;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CSCAN,
        ST_CDONE,
        ST_PSCAN,
        ST_PDONE,
        ST_FL_RD,
        ST_FL_OUT,
        ST_FL_CLR,
        ST_REPLY,
        ST_EMIT_HIT,
        ST_EMIT_B,
        ST_EMIT_D,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic  load;
        logic  clr_idx;
        logic  inc_idx;
        logic  scan_cache;
        logic  scan_pend;
        logic  cache_wr;
        logic  send_upd;
        logic  tick_step;
        logic  k_clr;
        logic  fl_rd;
        logic  k_inc;
        logic  fl_clr;
        logic  emit;
        t_emit emit_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       pass_ip4;
        logic       pass_arp;
        logic       last_c;
        logic       last_p;
        logic       last_t;
        logic       c_found;
        logic       p_found;
        logic       send_emit;
        logic       reply;
        logic       flush_none;
        logic       k_last;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== src/arpre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module arpre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/arpre_ctrl.sv =====
// Sequencer of the ARP resolution engine: walks each item through scans,
// updates and result beats. Depends on arpre_pkg.
`default_nettype none
module arpre_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire arpre_pkg::t_stat i_stat,
    output arpre_pkg::t_cmd      o_cmd
);
    import arpre_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.emit_sel = EM_HIT;
        o_s_tready     = 1'b0;
        n_state        = r_state;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.clr_idx = 1'b1;
                case (i_stat.op)
                    OP_SEND: n_state = ST_CSCAN;
                    OP_RECV: begin
                        if (i_stat.pass_ip4) begin
                            n_state = ST_EMIT_D;
                        end else if (i_stat.pass_arp) begin
                            n_state = ST_CSCAN;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    OP_TICK: n_state = ST_TICK;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_CSCAN: begin
                o_cmd.scan_cache = 1'b1;
                o_cmd.inc_idx    = 1'b1;
                if (i_stat.last_c) begin
                    n_state = ST_CDONE;
                end
            end
            ST_CDONE: begin
                o_cmd.clr_idx = 1'b1;
                if (i_stat.op == OP_SEND) begin
                    n_state = i_stat.c_found ? ST_EMIT_HIT : ST_PSCAN;
                end else begin
                    o_cmd.cache_wr = 1'b1;
                    n_state        = ST_PSCAN;
                end
            end
            ST_PSCAN: begin
                o_cmd.scan_pend = 1'b1;
                o_cmd.inc_idx   = 1'b1;
                if (i_stat.last_p) begin
                    n_state = ST_PDONE;
                end
            end
            ST_PDONE: begin
                o_cmd.k_clr = 1'b1;
                if (i_stat.op == OP_SEND) begin
                    o_cmd.send_upd = 1'b1;
                    n_state        = i_stat.send_emit ? ST_EMIT_B : ST_IDLE;
                end else if (i_stat.p_found) begin
                    n_state = i_stat.flush_none ? ST_FL_CLR : ST_FL_RD;
                end else begin
                    n_state = i_stat.reply ? ST_REPLY : ST_IDLE;
                end
            end
            ST_FL_RD: begin
                o_cmd.fl_rd = 1'b1;
                n_state     = ST_FL_OUT;
            end
            ST_FL_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_FLUSH;
                    o_cmd.k_inc    = 1'b1;
                    n_state        = i_stat.k_last ? ST_FL_CLR : ST_FL_RD;
                end
            end
            ST_FL_CLR: begin
                o_cmd.fl_clr = 1'b1;
                n_state      = i_stat.reply ? ST_REPLY : ST_IDLE;
            end
            ST_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_REPLY;
                    n_state        = ST_IDLE;
                end
            end
            ST_EMIT_HIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_HIT;
                    n_state        = ST_IDLE;
                end
            end
            ST_EMIT_B: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_BCAST;
                    n_state        = ST_IDLE;
                end
            end
            ST_EMIT_D: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_DELIVER;
                    n_state        = ST_IDLE;
                end
            end
            ST_TICK: begin
                o_cmd.tick_step = 1'b1;
                o_cmd.inc_idx   = 1'b1;
                if (i_stat.last_t) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/arpre_dp.sv =====
// Datapath of the ARP resolution engine: item latch, cache and pending tables,
// scan trackers, waiting-handle RAM and output register. Depends on arpre_pkg, arpre_ram.
`default_nettype none
module arpre_dp #(
    parameter int CACHE_ENTRIES   = arpre_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpre_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpre_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire arpre_pkg::t_cmd           i_cmd,
    output arpre_pkg::t_stat               o_stat,
    input  wire logic [arpre_pkg::IN_W-1:0] i_s_tdata,
    input  wire logic [1:0]                i_s_tuser,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_addr,
    input  wire logic [arpre_pkg::CFG_W-1:0] i_cfg_data,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [arpre_pkg::OUT_W-1:0]    o_m_tdata,
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);
    import arpre_pkg::*;

    localparam int C    = CACHE_ENTRIES;
    localparam int P    = PENDING_ENTRIES;
    localparam int Q    = QUEUE_DEPTH;
    localparam int CW   = (C > 1) ? $clog2(C) : 1;
    localparam int PW   = (P > 1) ? $clog2(P) : 1;
    localparam int MAXN = (C > P) ? C : P;
    localparam int IW   = (MAXN > 1) ? $clog2(MAXN) : 1;
    localparam int QCW  = $clog2(Q + 1);
    localparam int RD   = P * Q;
    localparam int AW   = (RD > 1) ? $clog2(RD) : 1;

    // configuration
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip, r_lifetime, r_holdoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac  <= '0;
            r_own_ip   <= '0;
            r_lifetime <= LIFETIME_RST;
            r_holdoff  <= HOLDOFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_OWN_MAC:  r_own_mac  <= i_cfg_data;
                REG_OWN_IP:   r_own_ip   <= i_cfg_data[31:0];
                REG_LIFETIME: r_lifetime <= i_cfg_data[31:0];
                REG_HOLDOFF:  r_holdoff  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // item latch
    logic [1:0]  r_op;
    logic [31:0] r_nh, r_sip, r_tip;
    logic [15:0] r_h, r_et, r_opc, r_el;
    logic [47:0] r_dst, r_smac;
    logic        r_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_s_tuser;
            r_nh   <= i_s_tdata[IN_NH +: 32];
            r_h    <= i_s_tdata[IN_HND +: 16];
            r_dst  <= i_s_tdata[IN_DST +: 48];
            r_et   <= i_s_tdata[IN_ET +: 16];
            r_ok   <= i_s_tdata[IN_OK];
            r_opc  <= i_s_tdata[IN_OPC +: 16];
            r_sip  <= i_s_tdata[IN_SIP +: 32];
            r_smac <= i_s_tdata[IN_SMAC +: 48];
            r_tip  <= i_s_tdata[IN_TIP +: 32];
            r_el   <= i_s_tdata[IN_EL +: 16];
        end
    end

    logic        mac_ok, reply;
    logic [31:0] key;
    assign mac_ok = ((r_dst == r_own_mac) || (r_dst == MAC_BCAST)) && r_ok;
    assign reply  = (r_opc == ARP_OP_REQ) && (r_tip == r_own_ip);
    assign key    = (r_op == OP_SEND) ? r_nh : r_sip;

    // scan index
    logic [IW-1:0] r_idx;
    logic [CW-1:0] ci;
    logic [PW-1:0] pi;
    logic          in_c, in_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    assign ci   = r_idx[CW-1:0];
    assign pi   = r_idx[PW-1:0];
    assign in_c = {1'b0, r_idx} < (IW+1)'(C);
    assign in_p = {1'b0, r_idx} < (IW+1)'(P);

    // tables
    logic            r_cvalid [C];
    logic [31:0]     r_cip    [C];
    logic [47:0]     r_cmac_t [C];
    logic [31:0]     r_cage   [C];
    logic            r_pvalid [P];
    logic [31:0]     r_pip    [P];
    logic [31:0]     r_page_t [P];
    logic [QCW-1:0]  r_pcnt_t [P];

    // scan trackers
    logic          r_cfound_v, r_cfree_v;
    logic [CW-1:0] r_cfound, r_cfree, r_cbest;
    logic [31:0]   r_cbest_age;
    logic [47:0]   r_cmac;
    logic          r_pfound_v, r_pfree_v;
    logic [PW-1:0] r_pfound, r_pfree, r_pbest;
    logic [31:0]   r_pbest_age, r_page;
    logic [QCW-1:0] r_pcnt;
    logic [CW-1:0] c_sel;
    logic [PW-1:0] p_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfound_v <= 1'b0;
            r_cfree_v  <= 1'b0;
            r_pfound_v <= 1'b0;
            r_pfree_v  <= 1'b0;
        end else if (i_cmd.clr_idx) begin
            // cache flags hold across the pending scan, cleared at its own start
            if (r_op == OP_SEND || !i_cmd.clr_idx || r_idx == '0) begin
                r_pfound_v <= 1'b0;
                r_pfree_v  <= 1'b0;
            end
            if (!i_cmd.cache_wr && !r_cfound_v && !r_cfree_v) begin
                r_cfound_v <= 1'b0;
            end
            if (i_cmd.cache_wr || r_idx == '0) begin
                r_cfound_v <= r_cfound_v && !(r_idx == '0 && !i_cmd.cache_wr);
            end
        end else begin
            if (i_cmd.scan_cache) begin
                if (r_idx == '0) begin
                    r_cfound_v <= 1'b0;
                    r_cfree_v  <= 1'b0;
                end
                if (r_cvalid[ci] && r_cip[ci] == key && (!r_cfound_v || r_idx == '0)) begin
                    r_cfound_v <= 1'b1;
                end
                if (!r_cvalid[ci] && (!r_cfree_v || r_idx == '0)) begin
                    r_cfree_v <= 1'b1;
                end
            end
            if (i_cmd.scan_pend) begin
                if (r_idx == '0) begin
                    r_pfound_v <= 1'b0;
                    r_pfree_v  <= 1'b0;
                end
                if (r_pvalid[pi] && r_pip[pi] == key && (!r_pfound_v || r_idx == '0)) begin
                    r_pfound_v <= 1'b1;
                end
                if (!r_pvalid[pi] && (!r_pfree_v || r_idx == '0)) begin
                    r_pfree_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_cache) begin
            if (r_cvalid[ci] && r_cip[ci] == key && (!r_cfound_v || r_idx == '0)) begin
                r_cfound <= ci;
                r_cmac   <= r_cmac_t[ci];
            end
            if (!r_cvalid[ci] && (!r_cfree_v || r_idx == '0)) begin
                r_cfree <= ci;
            end
            if (r_idx == '0 || r_cage[ci] > r_cbest_age) begin
                r_cbest     <= ci;
                r_cbest_age <= r_cage[ci];
            end
        end
        if (i_cmd.scan_pend) begin
            if (r_pvalid[pi] && r_pip[pi] == key && (!r_pfound_v || r_idx == '0)) begin
                r_pfound <= pi;
                r_page   <= r_page_t[pi];
                r_pcnt   <= r_pcnt_t[pi];
            end
            if (!r_pvalid[pi] && (!r_pfree_v || r_idx == '0)) begin
                r_pfree <= pi;
            end
            if (r_idx == '0 || r_page_t[pi] > r_pbest_age) begin
                r_pbest     <= pi;
                r_pbest_age <= r_page_t[pi];
            end
        end
    end

    assign c_sel = r_cfound_v ? r_cfound : (r_cfree_v ? r_cfree : r_cbest);
    assign p_sel = r_pfound_v ? r_pfound : (r_pfree_v ? r_pfree : r_pbest);

    // saturating age sums for the tick walk
    logic [32:0] csum, psum;
    logic [31:0] cage_n, page_n;
    assign csum   = {1'b0, r_cage[ci]} + 33'(r_el);
    assign psum   = {1'b0, r_page_t[pi]} + 33'(r_el);
    assign cage_n = csum[32] ? '1 : csum[31:0];
    assign page_n = psum[32] ? '1 : psum[31:0];

    logic tick_c, tick_p, page_over, q_room;
    assign tick_c    = i_cmd.tick_step && in_c && r_cvalid[ci];
    assign tick_p    = i_cmd.tick_step && in_p && r_pvalid[pi];
    assign page_over = r_page > r_holdoff;
    assign q_room    = r_pcnt < QCW'(Q);

    // cache table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < C; i++) begin
                r_cvalid[i] <= 1'b0;
            end
        end else if (i_cmd.cache_wr) begin
            r_cvalid[c_sel] <= 1'b1;
        end else if (tick_c && cage_n >= r_lifetime) begin
            r_cvalid[ci] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cache_wr) begin
            r_cip[c_sel]    <= r_sip;
            r_cmac_t[c_sel] <= r_smac;
            r_cage[c_sel]   <= '0;
        end else if (tick_c) begin
            r_cage[ci] <= cage_n;
        end
    end

    // pending table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < P; i++) begin
                r_pvalid[i] <= 1'b0;
                r_pcnt_t[i] <= '0;
            end
        end else if (i_cmd.send_upd) begin
            if (r_pfound_v) begin
                if (q_room) begin
                    r_pcnt_t[p_sel] <= r_pcnt + QCW'(1);
                end
            end else begin
                r_pvalid[p_sel] <= 1'b1;
                r_pcnt_t[p_sel] <= QCW'(1);
            end
        end else if (i_cmd.fl_clr) begin
            r_pvalid[r_pfound] <= 1'b0;
            r_pcnt_t[r_pfound] <= '0;
        end else if (tick_p && page_n >= r_holdoff) begin
            r_pvalid[pi] <= 1'b0;
            r_pcnt_t[pi] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send_upd) begin
            if (!r_pfound_v) begin
                r_pip[p_sel] <= r_nh;
            end
            if (!r_pfound_v || page_over) begin
                r_page_t[p_sel] <= '0;
            end
        end else if (i_cmd.fl_clr) begin
            r_page_t[r_pfound] <= '0;
        end else if (tick_p) begin
            r_page_t[pi] <= page_n;
        end
    end

    // waiting handles
    logic [QCW-1:0] r_k;
    logic [7:0]     flush_n;
    logic           k_last;
    logic [AW-1:0]  waddr, raddr;
    logic           ram_we;
    logic [15:0]    ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + QCW'(1);
        end
    end

    assign flush_n = (8'(r_pcnt) > 8'(FLUSH_MAX)) ? 8'(FLUSH_MAX) : 8'(r_pcnt);
    assign k_last  = 8'(r_k) == (flush_n - 8'd1);
    assign ram_we  = i_cmd.send_upd && (!r_pfound_v || q_room);
    assign waddr   = AW'(p_sel) * AW'(Q) + (r_pfound_v ? AW'(r_pcnt) : AW'(0));
    assign raddr   = AW'(r_pfound) * AW'(Q) + AW'(r_k);

    arpre_ram #(
        .WIDTH (16),
        .DEPTH (RD)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (r_h),
        .i_re    (i_cmd.fl_rd),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // output register
    logic        r_ovalid, r_olast;
    t_kind       r_okind;
    logic [47:0] r_omac;
    logic [15:0] r_ohnd;
    logic [31:0] r_otip;
    logic        out_free;

    assign out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.emit_sel)
                EM_BCAST: begin
                    r_okind <= KIND_ARP_REQ;
                    r_omac  <= MAC_BCAST;
                    r_ohnd  <= '0;
                    r_otip  <= r_nh;
                    r_olast <= 1'b1;
                end
                EM_DELIVER: begin
                    r_okind <= KIND_DELIVER;
                    r_omac  <= '0;
                    r_ohnd  <= r_h;
                    r_otip  <= '0;
                    r_olast <= 1'b1;
                end
                EM_FLUSH: begin
                    r_okind <= KIND_IPV4;
                    r_omac  <= r_smac;
                    r_ohnd  <= ram_rdata;
                    r_otip  <= '0;
                    r_olast <= k_last && !reply;
                end
                EM_REPLY: begin
                    r_okind <= KIND_ARP_REP;
                    r_omac  <= r_smac;
                    r_ohnd  <= '0;
                    r_otip  <= r_sip;
                    r_olast <= 1'b1;
                end
                default: begin
                    r_okind <= KIND_IPV4;
                    r_omac  <= r_cmac;
                    r_ohnd  <= r_h;
                    r_otip  <= '0;
                    r_olast <= 1'b1;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_otip, r_ohnd, r_omac};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    // status
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.pass_ip4   = mac_ok && (r_et == ETH_IPV4);
        o_stat.pass_arp   = mac_ok && (r_et == ETH_ARP);
        o_stat.last_c     = r_idx == IW'(C - 1);
        o_stat.last_p     = r_idx == IW'(P - 1);
        o_stat.last_t     = r_idx == IW'(MAXN - 1);
        o_stat.c_found    = r_cfound_v;
        o_stat.p_found    = r_pfound_v;
        o_stat.send_emit  = !r_pfound_v || page_over;
        o_stat.reply      = reply;
        o_stat.flush_none = flush_n == 8'd0;
        o_stat.k_last     = k_last;
        o_stat.out_free   = out_free;
    end
endmodule
`default_nettype wire

// ===== src/arp_resolution_engine.sv =====
// Top level of the ARP resolution engine: sequencer plus datapath.
// Depends on arpre_pkg, arpre_ctrl, arpre_dp (and arpre_ram through it).
//
// One item at a time. A send walks the cache one entry per cycle, then the
// pending table one entry per cycle; a cache hit skips the pending walk. An
// ARP frame takes the same walks, then reads each flushed handle through the
// registered read of the waiting-handle RAM, retires the pending entry and
// sends a reply if one is due. A tick ages one cache and one pending entry
// per cycle. A received IPv4 frame goes straight to its deliver beat. Results
// sit in an output register; the next item is taken while the last beat of
// the previous one still waits.
`default_nettype none
module arp_resolution_engine #(
    parameter int CACHE_ENTRIES   = arpre_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpre_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpre_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // next_hop_addr, datagram_handle, frame_dst_mac, frame_ethertype, payload_ok,
    // arp_opcode, arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms
    input  wire logic [arpre_pkg::IN_W-1:0]  s_axis_tdata,
    // op
    input  wire logic [1:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // dest_mac, out_handle, target_ip
    output logic [arpre_pkg::OUT_W-1:0]      m_axis_tdata,
    // kind
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_addr,
    input  wire logic [arpre_pkg::CFG_W-1:0] i_cfg_data
);
    import arpre_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    arpre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arpre_dp #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire

// ===== src/arpre_checker.sv =====
// Port-level checks of the ARP resolution engine, bound to the top level.
// Depends on arpre_pkg.
`default_nettype none
module arpre_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [arpre_pkg::OUT_W-1:0] m_axis_tdata,
    input wire logic [1:0]                 m_axis_tuser,
    input wire logic                       m_axis_tlast
);
    import arpre_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ARP_REQ |->
            m_axis_tdata[47:0] == MAC_BCAST && m_axis_tdata[63:48] == 16'd0 && m_axis_tlast)
        else $error("malformed ARP request beat");

    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DELIVER |->
            m_axis_tdata[47:0] == 48'd0 && m_axis_tdata[95:64] == 32'd0 && m_axis_tlast)
        else $error("malformed deliver beat");

    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ARP_REP |->
            m_axis_tdata[63:48] == 16'd0 && m_axis_tlast)
        else $error("malformed ARP reply beat");
endmodule

bind arp_resolution_engine arpre_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== tb/arp_resolution_engine_test.sv =====
// Self-checking testbench for arp_resolution_engine: directed and random beats,
// a scoreboard class that predicts every output beat. Depends on arpre_pkg and the src RTL.
`default_nettype none
module arp_resolution_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import arpre_pkg::*;

    localparam int NCACHE  = CACHE_ENTRIES_DEF;
    localparam int NPEND   = PENDING_ENTRIES_DEF;
    localparam int QDEPTH  = QUEUE_DEPTH_DEF;
    localparam int LIMIT   = 300000;
    localparam int NRANDOM = 81;
    localparam int NPOOL   = 12;
    localparam int HOLD_CYCLES = 300;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [15:0] ARP_OP_REPLY = 16'd2;
    localparam logic [47:0] OWN_MAC      = 48'h02_00_00_00_00_01;
    localparam logic [31:0] OWN_IP       = 32'h0A00_00FE;
    localparam logic [31:0] LIFETIME     = 32'd4000;
    localparam logic [31:0] HOLDOFF      = 32'd1500;
    localparam logic [31:0] HOLDOFF_LOW  = 32'd300;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] nh;
        logic [15:0] hnd;
        logic [47:0] dst;
        logic [15:0] et;
        logic        ok;
        logic [15:0] opc;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] tip;
        logic [15:0] el;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] mac;
        logic [15:0] hnd;
        logic [31:0] tip;
        logic        last;
    } t_beat;

    class t_arp_scoreboard;
        bit [47:0] own_mac;
        bit [31:0] own_ip, lifetime, holdoff;
        bit        c_v[NCACHE];
        bit [31:0] c_ip[NCACHE];
        bit [47:0] c_mac[NCACHE];
        bit [31:0] c_age[NCACHE];
        bit        p_v[NPEND];
        bit [31:0] p_ip[NPEND];
        bit [31:0] p_age[NPEND];
        bit [15:0] wq[NPEND][QDEPTH];
        int        wcnt[NPEND];
        t_beat     res_q[$];
        t_beat     expected_q[$];
        int        errors, beats, items;
        int        kind_seen[4];

        function new();
            own_mac  = '0;
            own_ip   = '0;
            lifetime = LIFETIME_RST;
            holdoff  = HOLDOFF_RST;
            errors   = 0;
            beats    = 0;
            items    = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            foreach (c_v[i]) begin
                c_v[i]   = 0;
                c_ip[i]  = '0;
                c_mac[i] = '0;
                c_age[i] = '0;
            end
            foreach (p_v[i]) begin
                p_v[i]   = 0;
                p_ip[i]  = '0;
                p_age[i] = '0;
                wcnt[i]  = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [47:0] v);
            case (idx)
                REG_OWN_MAC:  own_mac = v;
                REG_OWN_IP:   own_ip = v[31:0];
                REG_LIFETIME: lifetime = v[31:0];
                REG_HOLDOFF:  holdoff = v[31:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] sat_add(bit [31:0] a, bit [15:0] d);
            bit [32:0] s;
            s = {1'b0, a} + 33'(d);
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function int cache_find(bit [31:0] ip);
            for (int i = 0; i < NCACHE; i++) if (c_v[i] && c_ip[i] == ip) return i;
            return -1;
        endfunction

        function int pend_find(bit [31:0] ip);
            for (int i = 0; i < NPEND; i++) if (p_v[i] && p_ip[i] == ip) return i;
            return -1;
        endfunction

        // free slot first, else the oldest entry (lowest index wins ties)
        function int cache_slot();
            int best;
            best = 0;
            for (int i = 0; i < NCACHE; i++) if (!c_v[i]) return i;
            for (int i = 1; i < NCACHE; i++) if (c_age[i] > c_age[best]) best = i;
            return best;
        endfunction

        function int pend_slot();
            int best;
            best = 0;
            for (int i = 0; i < NPEND; i++) if (!p_v[i]) return i;
            for (int i = 1; i < NPEND; i++) if (p_age[i] > p_age[best]) best = i;
            return best;
        endfunction

        function void emit(t_kind k, bit [47:0] mac, bit [15:0] h, bit [31:0] tip);
            t_beat b;
            if (res_q.size() >= MAX_RESULTS) return;
            b.kind = k;
            b.mac  = mac;
            b.hnd  = h;
            b.tip  = tip;
            b.last = 1'b0;
            res_q.push_back(b);
        endfunction

        function void do_send(t_req it);
            int c, p;
            c = cache_find(it.nh);
            if (c >= 0) begin
                emit(KIND_IPV4, c_mac[c], it.hnd, 32'd0);
                return;
            end
            p = pend_find(it.nh);
            if (p >= 0) begin
                if (wcnt[p] < QDEPTH) begin
                    wq[p][wcnt[p]] = it.hnd;
                    wcnt[p]++;
                end
                // hold the repeat until the holdoff has run out
                if (p_age[p] <= holdoff) return;
            end else begin
                p = pend_slot();
                p_v[p]   = 1;
                p_ip[p]  = it.nh;
                wq[p][0] = it.hnd;
                wcnt[p]  = 1;
            end
            p_age[p] = '0;
            emit(KIND_ARP_REQ, MAC_BCAST, 16'd0, it.nh);
        endfunction

        function void do_arp(t_req it);
            int c, p, cnt;
            c = cache_find(it.sip);
            if (c < 0) c = cache_slot();
            c_v[c]   = 1;
            c_ip[c]  = it.sip;
            c_mac[c] = it.smac;
            c_age[c] = '0;
            p = pend_find(it.sip);
            if (p >= 0) begin
                cnt = (wcnt[p] > QDEPTH) ? QDEPTH : wcnt[p];
                for (int i = 0; i < cnt && res_q.size() < MAX_RESULTS - 1; i++)
                    emit(KIND_IPV4, it.smac, wq[p][i], 32'd0);
                p_v[p]   = 0;
                p_age[p] = '0;
                wcnt[p]  = 0;
            end
            if (it.opc == ARP_OP_REQ && it.tip == own_ip)
                emit(KIND_ARP_REP, it.smac, 16'd0, it.sip);
        endfunction

        function void do_tick(bit [15:0] d);
            for (int i = 0; i < NCACHE; i++) begin
                if (c_v[i]) begin
                    c_age[i] = sat_add(c_age[i], d);
                    if (c_age[i] >= lifetime) c_v[i] = 0;
                end
            end
            for (int i = 0; i < NPEND; i++) begin
                if (p_v[i]) begin
                    p_age[i] = sat_add(p_age[i], d);
                    if (p_age[i] >= holdoff) begin
                        p_v[i]  = 0;
                        wcnt[i] = 0;
                    end
                end
            end
        endfunction

        function void note_item(t_req it);
            items++;
            res_q.delete();
            case (it.op)
                OP_SEND: do_send(it);
                OP_RECV: begin
                    if ((it.dst == own_mac || it.dst == MAC_BCAST) && it.ok) begin
                        if (it.et == ETH_IPV4) begin
                            emit(KIND_DELIVER, 48'd0, it.hnd, 32'd0);
                        end else if (it.et == ETH_ARP) begin
                            do_arp(it);
                        end
                    end
                end
                OP_TICK: do_tick(it.el);
                default: ;
            endcase
            if (res_q.size() > 0) res_q[res_q.size() - 1].last = 1'b1;
            foreach (res_q[i]) expected_q.push_back(res_q[i]);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_beat(t_beat got);
            t_beat exp_b;
            beats++;
            kind_seen[int'(got.kind)]++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat of kind %0d", got.kind));
                return;
            end
            exp_b = expected_q.pop_front();
            if (got !== exp_b) begin
                report($sformatf("kind %0d/%0d mac %h/%h hnd %h/%h tip %h/%h last %b/%b",
                                 got.kind, exp_b.kind, got.mac, exp_b.mac, got.hnd,
                                 exp_b.hnd, got.tip, exp_b.tip, got.last, exp_b.last));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_data;

    t_arp_scoreboard sb = new();
    t_beat           mon_beat;
    int              cycles = 0;
    int              hold_left = 0;
    int              rx_gap = 0;
    int              rx_roll;
    bit              long_done = 0;

    arp_resolution_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [IN_W-1:0] pack_item(t_req it);
        logic [IN_W-1:0] d;
        d = '0;
        d[IN_NH +: 32]   = it.nh;
        d[IN_HND +: 16]  = it.hnd;
        d[IN_DST +: 48]  = it.dst;
        d[IN_ET +: 16]   = it.et;
        d[IN_OK]         = it.ok;
        d[IN_OPC +: 16]  = it.opc;
        d[IN_SIP +: 32]  = it.sip;
        d[IN_SMAC +: 48] = it.smac;
        d[IN_TIP +: 32]  = it.tip;
        d[IN_EL +: 16]   = it.el;
        return d;
    endfunction

    function automatic t_req unpack_item(logic [IN_W-1:0] d, logic [1:0] op);
        t_req it;
        it.op   = op;
        it.nh   = d[IN_NH +: 32];
        it.hnd  = d[IN_HND +: 16];
        it.dst  = d[IN_DST +: 48];
        it.et   = d[IN_ET +: 16];
        it.ok   = d[IN_OK];
        it.opc  = d[IN_OPC +: 16];
        it.sip  = d[IN_SIP +: 32];
        it.smac = d[IN_SMAC +: 48];
        it.tip  = d[IN_TIP +: 32];
        it.el   = d[IN_EL +: 16];
        return it;
    endfunction

    function automatic logic [31:0] pool_ip(int i);
        return 32'h0A00_0001 + 32'(i);
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic t_req mk_send(logic [31:0] ip, logic [15:0] h);
        t_req it;
        it     = '0;
        it.op  = OP_SEND;
        it.nh  = ip;
        it.hnd = h;
        return it;
    endfunction

    function automatic t_req mk_arp(logic [47:0] dst, logic [15:0] opc, logic [31:0] sip,
                                    logic [47:0] smac, logic [31:0] tip);
        t_req it;
        it      = '0;
        it.op   = OP_RECV;
        it.hnd  = 16'($urandom);
        it.dst  = dst;
        it.et   = ETH_ARP;
        it.ok   = 1'b1;
        it.opc  = opc;
        it.sip  = sip;
        it.smac = smac;
        it.tip  = tip;
        return it;
    endfunction

    function automatic t_req mk_ip4(logic [15:0] h);
        t_req it;
        it     = '0;
        it.op  = OP_RECV;
        it.hnd = h;
        it.dst = OWN_MAC;
        it.et  = ETH_IPV4;
        it.ok  = 1'b1;
        return it;
    endfunction

    function automatic t_req mk_tick(logic [15:0] el);
        t_req it;
        it    = '0;
        it.op = OP_TICK;
        it.el = el;
        return it;
    endfunction

    function automatic t_req rand_item();
        t_req it;
        int   r;
        it      = '0;
        it.hnd  = 16'($urandom);
        it.smac = rand_mac();
        r = int'($urandom_range(0, 99));
        if (r < 40) begin
            it.op = OP_SEND;
            it.nh = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                 : pool_ip(int'($urandom_range(0, NPOOL - 1)));
        end else if (r < 72) begin
            it.op = OP_RECV;
            r = int'($urandom_range(0, 9));
            it.dst = (r < 6) ? OWN_MAC : ((r < 8) ? MAC_BCAST : rand_mac());
            r = int'($urandom_range(0, 9));
            it.et = (r < 4) ? ETH_IPV4 : ((r < 9) ? ETH_ARP : 16'($urandom));
            it.ok = ($urandom_range(0, 9) != 0);
            r = int'($urandom_range(0, 9));
            it.opc = (r < 5) ? ARP_OP_REQ : ((r < 9) ? ARP_OP_REPLY : 16'($urandom));
            it.sip = ($urandom_range(0, 9) < 7) ? pool_ip(int'($urandom_range(0, NPOOL - 1)))
                                                 : 32'($urandom);
            it.tip = ($urandom_range(0, 1) == 0) ? OWN_IP : 32'($urandom);
        end else if (r < 95) begin
            it.op = OP_TICK;
            it.el = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 900)) : 16'hFFFF;
        end else begin
            it.op = OP_UNUSED;
            it.nh = pool_ip(0);
            it.el = 16'hFFFF;
        end
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 4));
        return int'($urandom_range(15, 40));
    endfunction

    task automatic send_item(t_req it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid and wait until no item and no beat is left in flight
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk);
        while (!(s_axis_tready && !m_axis_tvalid && sb.expected_q.size() == 0));
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [47:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        sb.write_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // result sink: random gaps, a few long ones, and one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (!long_done && sb.items >= 50) begin
            long_done = 1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap--;
        end else begin
            rx_roll = int'($urandom_range(0, 99));
            if (rx_roll < 3) begin
                rx_gap = int'($urandom_range(15, 40));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (rx_roll < 75);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(unpack_item(s_axis_tdata, s_axis_tuser));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                mon_beat.kind = t_kind'(m_axis_tuser);
                mon_beat.mac  = m_axis_tdata[47:0];
                mon_beat.hnd  = m_axis_tdata[63:48];
                mon_beat.tip  = m_axis_tdata[95:64];
                mon_beat.last = m_axis_tlast;
                sb.check_beat(mon_beat);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            sb.report("cycle limit reached");
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(REG_OWN_MAC, OWN_MAC);
        cfg_write(REG_OWN_IP, 48'(OWN_IP));
        cfg_write(REG_LIFETIME, 48'(LIFETIME));
        cfg_write(REG_HOLDOFF, 48'(HOLDOFF));

        // overflow one queue, then resolve it
        for (int i = 0; i < 10; i++) send_item(mk_send(pool_ip(0), 16'(16'h1000 + i)));
        send_item(mk_arp(OWN_MAC, ARP_OP_REPLY, pool_ip(0), 48'h0A_0B_0C_0D_0E_0F, pool_ip(5)));
        send_item(mk_send(pool_ip(0), 16'h2000));
        send_item(mk_arp(MAC_BCAST, ARP_OP_REQ, pool_ip(1), rand_mac(), OWN_IP));
        send_item(mk_ip4(16'h3000));
        send_item(mk_tick(16'hFFFF));

        // overrun the pending table, then flush with a reply
        for (int i = 2; i <= 10; i++) send_item(mk_send(pool_ip(i), 16'(16'h4000 + i)));
        send_item(mk_send(pool_ip(10), 16'h4100));
        send_item(mk_arp(OWN_MAC, ARP_OP_REQ, pool_ip(10), rand_mac(), OWN_IP));

        // shrink the holdoff under a waiting request
        send_item(mk_send(pool_ip(11), 16'h5000));
        send_item(mk_tick(16'd1000));
        drain();
        cfg_write(REG_HOLDOFF, 48'(HOLDOFF_LOW));
        send_item(mk_send(pool_ip(11), 16'h5001));
        drain();
        cfg_write(REG_HOLDOFF, 48'(HOLDOFF));

        for (int i = 0; i < NRANDOM; i++) send_item(rand_item());
        drain();

        $display("run covered %0d items and %0d beats: %0d ipv4, %0d request, %0d reply, %0d up",
                 sb.items, sb.beats, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
                 sb.kind_seen[3]);
        $display("with queue overflow, table replacement, flushes, a holdoff change and a long stall");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
src/arpre_pkg.sv
src/arpre_ram.sv
src/arpre_ctrl.sv
src/arpre_dp.sv
src/arp_resolution_engine.sv
src/arpre_checker.sv
tb/arp_resolution_engine_test.sv
